/* src/redundant_move_filter_assert.svh */
// Assertion macros shared by the filter RTL.
`ifndef REDUNDANT_MOVE_FILTER_ASSERT_SVH
`define REDUNDANT_MOVE_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMF_ASSERT(lbl, prop, msg)
`define RMF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/rmf_pkg.sv */
package rmf_pkg;

    localparam int ID_FIELD_BITS = 16;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_MOVE  = 2'd2,
        KIND_CALL  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [ID_FIELD_BITS-1:0] dest_id;
        logic [ID_FIELD_BITS-1:0] src_id;
        logic                     block_end;
    } instr_t;

    typedef struct packed {
        logic keep;
        logic block_changed;
    } verdict_t;

endpackage

/* src/rmf_table.sv */
`include "redundant_move_filter_assert.svh"

module rmf_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int VALUE_BITS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rmf_pkg::instr_t   item,
    output rmf_pkg::verdict_t verdict
);
    import rmf_pkg::*;

    // ids are masked to VALUE_BITS; the field itself carries no more than 16
    localparam int ID_W = (VALUE_BITS < ID_FIELD_BITS) ? VALUE_BITS : ID_FIELD_BITS;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [ID_W-1:0]          low_reg  [TABLE_ENTRIES];
    logic [ID_W-1:0]          high_reg [TABLE_ENTRIES];
    logic                     changed_reg, changed_next;

    logic [ID_W-1:0]          dest, src, lo, hi;
    logic [TABLE_ENTRIES-1:0] match, kept, hit, free_vec, free_oh, wr_en;
    logic                     known, changed_now, do_record;

    always_comb
    begin
        dest = item.dest_id[ID_W-1:0];
        src  = item.src_id[ID_W-1:0];
        lo   = (dest < src) ? dest : src;
        hi   = (dest < src) ? src : dest;

        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (low_reg[i] == lo) && (high_reg[i] == hi);
            // pairs that survive the drop of the destination
            kept[i]  = valid_reg[i] && !((low_reg[i] == dest) || (high_reg[i] == dest));
            hit[i]   = kept[i] && (low_reg[i] == lo);
        end

        known     = (dest == src) || (|match);
        // lowest free slot after the drop, one-hot; zero when full
        free_vec  = ~kept;
        free_oh   = free_vec & (~free_vec + TABLE_ENTRIES'(1));
        do_record = (item.kind == KIND_MOVE) && !known;
        wr_en     = do_record ? ((|hit) ? hit : free_oh) : '0;

        valid_next  = valid_reg;
        changed_now = changed_reg;
        unique case (item.kind)
            KIND_NONE:  ;
            KIND_WRITE: valid_next = kept;
            KIND_MOVE:
            begin
                if (known)
                    changed_now = 1'b1;
                else
                    valid_next = kept | wr_en;
            end
            KIND_CALL:  valid_next = '0;
            default:    ;
        endcase

        changed_next = changed_now;
        if (item.block_end)
        begin
            valid_next   = '0;
            changed_next = 1'b0;
        end

        verdict.keep          = !((item.kind == KIND_MOVE) && known);
        verdict.block_changed = changed_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            changed_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg   <= valid_next;
            changed_reg <= changed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (step && wr_en[i])
            begin
                low_reg[i]  <= lo;
                high_reg[i] <= hi;
            end
        end
    end

    `RMF_ASSERT(a_end_clears, step && item.block_end |=> (valid_reg == '0) && !changed_reg,
                "table or flag survived block end")
    `RMF_ASSERT(a_call_clears, step && (item.kind == KIND_CALL) |=> valid_reg == '0,
                "table survived a call")
    `RMF_ASSERT(a_erase_stable, step && !verdict.keep && !item.block_end |=> $stable(valid_reg),
                "erased move altered the table")

endmodule

/* src/redundant_move_filter.sv */
// An accepted instruction word passes the input register, the table match
// and update, and the result register before its verdict word appears.
// Throughput: one word per cycle while verdict_stall is low; the whole table is matched in parallel.
// Reset (rst_n, async, active low) empties the table and clears the
// changed flag; no clearing pass, words are accepted right after reset.
`include "redundant_move_filter_assert.svh"

module redundant_move_filter #(
    parameter int TABLE_ENTRIES = 16,
    parameter int VALUE_BITS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              instr_valid,
    output logic              instr_stall,
    input  rmf_pkg::instr_t   instr,
    output logic              verdict_valid,
    input  logic              verdict_stall,
    output rmf_pkg::verdict_t verdict
);
    import rmf_pkg::*;

    logic     hold_valid_reg, hold_valid_next;
    instr_t   hold_reg;
    logic     out_valid_reg, out_valid_next;
    verdict_t out_reg;
    verdict_t result;
    logic     advance, accept;

    // the held word moves on when the result register is free or being drained
    assign advance     = hold_valid_reg && (!out_valid_reg || !verdict_stall);
    assign instr_stall = hold_valid_reg && !advance;
    assign accept      = instr_valid && !instr_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
            hold_valid_next = 1'b1;
        else if (advance)
            hold_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!verdict_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_reg <= instr;
        if (advance)
            out_reg <= result;
    end

    rmf_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .VALUE_BITS    (VALUE_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (hold_reg),
        .verdict (result)
    );

    assign verdict_valid = out_valid_reg;
    assign verdict       = out_reg;

    `RMF_ASSERT(a_accept_fills, accept |=> hold_valid_reg,
                "accepted word not held")
    `RMF_ASSERT(a_advance_shows, advance |=> verdict_valid,
                "processed word produced no verdict")
    `RMF_ASSERT_ALWAYS(a_no_stall_empty, !hold_valid_reg |-> !instr_stall,
                       "stall raised with an empty input register")

endmodule

/* sim/redundant_move_filter_test.sv */
module redundant_move_filter_test;
    import rmf_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_WORDS  = 500;

    typedef logic [ID_FIELD_BITS-1:0] value_id_t;

    logic     clk           = 1'b0;
    logic     rst_n         = 1'b0;
    logic     instr_valid   = 1'b0;
    logic     instr_stall;
    instr_t   instr         = '0;
    logic     verdict_valid;
    logic     verdict_stall = 1'b0;
    verdict_t verdict;

    verdict_t    expected_verdicts[$];
    int unsigned failures    = 0;
    bit          no_idle     = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left  = 0;

    // predicted equality table and sticky erase flag
    bit        pair_used [TABLE_ENTRIES] = '{default: 1'b0};
    value_id_t pair_lo   [TABLE_ENTRIES];
    value_id_t pair_hi   [TABLE_ENTRIES];
    bit        erased_seen = 1'b0;

    redundant_move_filter #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .VALUE_BITS   (ID_FIELD_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instr        (instr),
        .verdict_valid(verdict_valid),
        .verdict_stall(verdict_stall),
        .verdict      (verdict)
    );

    always #5 clk = ~clk;

    function automatic void clear_equalities();
        for (int i = 0; i < TABLE_ENTRIES; i++)
            pair_used[i] = 1'b0;
    endfunction

    function automatic bit equality_known(value_id_t a, value_id_t b);
        value_id_t lo;
        value_id_t hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (a == b)
            return 1'b1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (pair_used[i] && pair_lo[i] == lo && pair_hi[i] == hi)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void forget_value(value_id_t id);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (pair_used[i] && (pair_lo[i] == id || pair_hi[i] == id))
                pair_used[i] = 1'b0;
    endfunction

    function automatic void note_equality(value_id_t a, value_id_t b);
        value_id_t lo;
        value_id_t hi;
        int        slot;
        lo   = (a < b) ? a : b;
        hi   = (a < b) ? b : a;
        slot = -1;
        // one pair per lower id: overwrite in place
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (pair_used[i] && pair_lo[i] == lo)
            begin
                pair_hi[i] = hi;
                return;
            end
        end
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
            if (!pair_used[i])
                slot = i;
        if (slot >= 0)
        begin
            pair_used[slot] = 1'b1;
            pair_lo[slot]   = lo;
            pair_hi[slot]   = hi;
        end
    endfunction

    function automatic verdict_t predict_verdict(instr_t w);
        verdict_t v;
        v.keep = 1'b1;
        case (w.kind)
            KIND_CALL:  clear_equalities();
            KIND_WRITE: forget_value(w.dest_id);
            KIND_MOVE:
            begin
                if (equality_known(w.dest_id, w.src_id))
                begin
                    v.keep      = 1'b0;
                    erased_seen = 1'b1;
                end
                else
                begin
                    forget_value(w.dest_id);
                    note_equality(w.dest_id, w.src_id);
                end
            end
            default: ;
        endcase
        v.block_changed = erased_seen;
        if (w.block_end)
        begin
            clear_equalities();
            erased_seen = 1'b0;
        end
        return v;
    endfunction

    task automatic send_word(input kind_t kind, input value_id_t dest_id,
                             input value_id_t src_id, input logic last);
        instr_t w;
        int     gap;
        w.kind      = kind;
        w.dest_id   = dest_id;
        w.src_id    = src_id;
        w.block_end = last;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            instr_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_valid <= 1'b1;
        instr       <= w;
        @(posedge clk);
        while (instr_stall)
            @(posedge clk);
        expected_verdicts.push_back(predict_verdict(w));
    endtask

    task automatic drain_verdicts();
        instr_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_verdict(input verdict_t got);
        verdict_t want;
        if (expected_verdicts.size() == 0)
        begin
            $error("unexpected verdict word: keep %0b block_changed %0b",
                   got.keep, got.block_changed);
            failures++;
            return;
        end
        want = expected_verdicts.pop_front();
        if (got.keep !== want.keep)
        begin
            $error("keep: expected %0b, actual %0b", want.keep, got.keep);
            failures++;
        end
        if (got.block_changed !== want.block_changed)
        begin
            $error("block_changed: expected %0b, actual %0b",
                   want.block_changed, got.block_changed);
            failures++;
        end
    endtask

    // receiver: check each word, then hold off for a random number of cycles
    always @(posedge clk)
    begin
        if (rst_n && verdict_valid && !verdict_stall)
        begin
            check_verdict(verdict);
            stall_left = no_idle ? 0 : $urandom_range(0, 13);
        end
        else if (stall_left != 0)
            stall_left--;
        verdict_stall <= (stall_left != 0);
    end

    always @(posedge clk)
    begin
        if ((instr_valid && !instr_stall) || (verdict_valid && !verdict_stall))
            idle_cycles = 0;
        else if (++idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_kinds();
        send_word(KIND_NONE,  16'hFFFF, 16'hFFFF, 1'b0);
        send_word(KIND_WRITE, 16'h0000, 16'hFFFF, 1'b0);
        send_word(KIND_MOVE,  16'hFFFF, 16'hFFFF, 1'b0);   // self move
        send_word(KIND_MOVE,  16'h0000, 16'h0000, 1'b0);
        send_word(KIND_CALL,  16'hFFFF, 16'h0000, 1'b1);
        send_word(KIND_NONE,  16'h0000, 16'h0000, 1'b1);
        drain_verdicts();
    endtask

    task automatic test_known_equalities();
        send_word(KIND_MOVE,  16'h0005, 16'hFFFF, 1'b0);
        send_word(KIND_MOVE,  16'hFFFF, 16'h0005, 1'b0);   // reversed pair
        send_word(KIND_MOVE,  16'h0005, 16'hFFFF, 1'b0);
        send_word(KIND_WRITE, 16'hFFFF, 16'h1234, 1'b0);   // kills the pair
        send_word(KIND_MOVE,  16'h0005, 16'hFFFF, 1'b0);
        send_word(KIND_CALL,  16'h0005, 16'hFFFF, 1'b0);
        send_word(KIND_MOVE,  16'hFFFF, 16'h0005, 1'b0);
        send_word(KIND_MOVE,  16'hFFFF, 16'h0005, 1'b1);
        send_word(KIND_MOVE,  16'hFFFF, 16'h0005, 1'b1);   // table empty again
        drain_verdicts();
    endtask

    task automatic test_pair_overwrite();
        send_word(KIND_MOVE, 16'd10, 16'd3, 1'b0);
        send_word(KIND_MOVE, 16'd11, 16'd3, 1'b0);   // lower id 3 re-paired
        send_word(KIND_MOVE, 16'd10, 16'd3, 1'b0);
        send_word(KIND_MOVE, 16'd11, 16'd3, 1'b1);
        drain_verdicts();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < TABLE_ENTRIES; i++)
            send_word(KIND_MOVE, value_id_t'(16'h0100 + i), value_id_t'(16'h8000 + i), 1'b0);
        send_word(KIND_MOVE, 16'h0120, 16'h8020, 1'b0);   // dropped, no room
        send_word(KIND_MOVE, 16'h8020, 16'h0120, 1'b0);
        send_word(KIND_MOVE, 16'h8000, 16'h0100, 1'b1);
        drain_verdicts();
    endtask

    // ids mostly from a narrow window so that equalities recur
    task automatic send_random_block(input int unsigned length, input bit noisy);
        value_id_t   base;
        value_id_t   dest;
        value_id_t   src;
        int unsigned pool;
        int unsigned pick;
        bit          open_end;
        kind_t       kind;
        base     = value_id_t'($urandom_range(0, 16'hFFFF));
        pool     = $urandom_range(1, 40);
        open_end = ($urandom_range(0, 9) == 0);
        for (int unsigned n = 0; n < length; n++)
        begin
            pick = $urandom_range(0, 99);
            kind = (pick < 55) ? KIND_MOVE : (pick < 75) ? KIND_WRITE :
                   (pick < 94) ? KIND_NONE : KIND_CALL;
            if (noisy)
            begin
                dest = value_id_t'($urandom_range(0, 16'hFFFF));
                src  = value_id_t'($urandom_range(0, 16'hFFFF));
            end
            else
            begin
                dest = value_id_t'(base + $urandom_range(0, pool));
                src  = ($urandom_range(0, 5) == 0) ? dest
                                                   : value_id_t'(base + $urandom_range(0, pool));
            end
            send_word(kind, dest, src,
                      (n == length - 1 && !open_end) || $urandom_range(0, 49) == 0);
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (3) send_random_block($urandom_range(10, 30), 1'b0);
        drain_verdicts();
        no_idle = 1'b0;
    endtask

    task automatic test_random_blocks();
        int unsigned sent;
        int unsigned length;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            length = $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0)
                no_idle = !no_idle;
            send_random_block(length, $urandom_range(0, 6) == 0);
            sent += length;
            if ($urandom_range(0, 19) == 0)
                drain_verdicts();
        end
        no_idle = 1'b0;
        drain_verdicts();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_kinds();
        test_known_equalities();
        test_pair_overwrite();
        test_full_table();
        test_back_to_back();
        test_random_blocks();
        repeat (8) @(posedge clk);
        if (failures == 0 && expected_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
